@@ design/rpc_pkg.sv @@
// Shared types and constants for the relation property checker.
package rpc_pkg;

    localparam int MAX_ELEMENTS = 16;
    localparam int IDX_W        = 4;
    localparam int SIZE_W       = 5;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

    localparam logic [1:0] OP_CLEAR = 2'd0;
    localparam logic [1:0] OP_ADD   = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    typedef struct packed {
        logic [1:0]       op;
        logic [IDX_W-1:0] row_index;
        logic [IDX_W-1:0] col_index;
    } cmd_t;

    typedef struct packed {
        logic is_reflexive;
        logic is_symmetric;
        logic is_antisymmetric;
        logic is_transitive;
    } res_t;

    typedef logic [MAX_ELEMENTS-1:0] row_t;

endpackage

@@ design/relation_property_checker.sv @@
// Binary relation matrix with clear/add commands and a row-walking property evaluator.
//
//  channel | direction | handshake            | word
//  --------+-----------+----------------------+------------------------------------
//  cmd     | in        | cmd_valid/cmd_stall  | op, row_index, col_index
//  res     | out       | res_valid/res_stall  | four property flags
//  cfg     | in        | cfg_valid/cfg_ready  | set_size (5 bits)
//
// Clear and an out-of-range add finish in S_IDLE, an in-range add also passes S_ADD_WR (row read-modify-write).
// Evaluate: accept in S_IDLE, S_EVAL reads on the single row port (for each i, row i, then
// rows 0..n-1), S_DRAIN, then S_OUT loads the output register; n = min(set_size, 16), n = 0 skips the walk.
// Reset invalidates all rows at once (per-row valid bits); set_size -> 16.
// A result waits in the output register while res is stalled; clears and adds are still
// taken meanwhile, an evaluate walks and then waits in S_OUT until the register frees.
module relation_property_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cmd_valid,
    output logic                             cmd_stall,
    input  rpc_pkg::cmd_t                    cmd,
    output logic                             res_valid,
    input  logic                             res_stall,
    output rpc_pkg::res_t                    res,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [rpc_pkg::SIZE_W-1:0]       cfg_data
);
    import rpc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_ADD_WR = 5'b00010,
        S_EVAL   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_OUT    = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;

    row_t              row_mem [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0] row_valid_reg, row_valid_next;
    logic [IDX_W-1:0]  rd_addr;
    row_t              rd_data_reg;
    logic              rd_valid_reg;

    logic [IDX_W-1:0]  add_row_reg, add_row_next;
    logic [IDX_W-1:0]  add_col_reg, add_col_next;

    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic              fetch_row_reg, fetch_row_next;

    logic              tag_valid_reg, tag_valid_next;
    logic              tag_is_row_reg, tag_is_row_next;
    logic [IDX_W-1:0]  tag_i_reg, tag_i_next;
    logic [IDX_W-1:0]  tag_j_reg, tag_j_next;

    row_t              ri_reg, ri_next;
    res_t              flags_reg, flags_next;

    logic              res_valid_reg, res_valid_next;
    res_t              res_reg, res_next;

    logic [SIZE_W-1:0] n_eff;
    logic [IDX_W-1:0]  last_idx;
    row_t              mask;
    row_t              row_now;
    row_t              col_bit;
    logic              cmd_take;
    logic              out_free;
    logic              mem_we;
    row_t              mem_wdata;
    logic              bit_a, bit_b;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    // size only changes between words
    assign cfg_ready = (state_reg == S_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign out_free  = !res_valid_reg || !res_stall;

    assign n_eff    = (size_reg > SIZE_W'(MAX_ELEMENTS)) ? SIZE_W'(MAX_ELEMENTS) : size_reg;
    assign last_idx = IDX_W'(n_eff - SIZE_W'(1));

    always_comb
    begin
        for (int k = 0; k < MAX_ELEMENTS; k++)
        begin
            mask[k] = (SIZE_W'(k) < n_eff);
        end
    end

    // rows never written since the last clear read as empty
    assign row_now   = (rd_valid_reg ? rd_data_reg : '0) & mask;
    assign bit_a     = ri_reg[tag_j_reg];
    assign bit_b     = row_now[tag_i_reg];
    assign col_bit   = row_t'(1) << add_col_reg;
    assign mem_we    = (state_reg == S_ADD_WR);
    assign mem_wdata = (rd_valid_reg ? rd_data_reg : '0) | col_bit;

    always_comb
    begin
        rd_addr = cmd.row_index;
        if (state_reg == S_EVAL)
        begin
            rd_addr = fetch_row_reg ? i_reg : j_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        row_valid_next  = row_valid_reg;
        add_row_next    = add_row_reg;
        add_col_next    = add_col_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        fetch_row_next  = fetch_row_reg;
        tag_valid_next  = 1'b0;
        tag_is_row_next = tag_is_row_reg;
        tag_i_next      = tag_i_reg;
        tag_j_next      = tag_j_reg;
        ri_next         = ri_reg;
        flags_next      = flags_reg;
        res_valid_next  = res_valid_reg && res_stall;
        res_next        = res_reg;

        // compare stage: data for the read issued last cycle
        if (tag_valid_reg)
        begin
            if (tag_is_row_reg)
            begin
                ri_next = row_now;
                if (!row_now[tag_i_reg])
                begin
                    flags_next.is_reflexive = 1'b0;
                end
            end
            else
            begin
                if (bit_a != bit_b)
                begin
                    flags_next.is_symmetric = 1'b0;
                end
                if ((tag_i_reg != tag_j_reg) && bit_a && bit_b)
                begin
                    flags_next.is_antisymmetric = 1'b0;
                end
                // R[i][j] set: row j must lie inside row i
                if (bit_a && ((row_now & ~ri_reg) != '0))
                begin
                    flags_next.is_transitive = 1'b0;
                end
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    case (cmd.op)
                        OP_CLEAR:
                        begin
                            row_valid_next = '0;
                        end
                        OP_ADD:
                        begin
                            add_row_next = cmd.row_index;
                            add_col_next = cmd.col_index;
                            if ((SIZE_W'(cmd.row_index) < n_eff)
                                && (SIZE_W'(cmd.col_index) < n_eff))
                            begin
                                state_next = S_ADD_WR;
                            end
                        end
                        OP_EVAL:
                        begin
                            flags_next     = '1;
                            i_next         = '0;
                            j_next         = '0;
                            fetch_row_next = 1'b1;
                            state_next     = (n_eff == '0) ? S_OUT : S_EVAL;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_ADD_WR:
            begin
                row_valid_next[add_row_reg] = 1'b1;
                state_next = S_IDLE;
            end
            S_EVAL:
            begin
                tag_valid_next  = 1'b1;
                tag_is_row_next = fetch_row_reg;
                tag_i_next      = i_reg;
                tag_j_next      = j_reg;
                if (fetch_row_reg)
                begin
                    fetch_row_next = 1'b0;
                    j_next         = '0;
                end
                else if (j_reg == last_idx)
                begin
                    if (i_reg == last_idx)
                    begin
                        state_next = S_DRAIN;
                    end
                    else
                    begin
                        i_next         = i_reg + IDX_W'(1);
                        fetch_row_next = 1'b1;
                    end
                end
                else
                begin
                    j_next = j_reg + IDX_W'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_next       = flags_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SIZE_RESET;
            row_valid_reg <= '0;
            tag_valid_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_valid_reg <= row_valid_next;
            tag_valid_reg <= tag_valid_next;
            res_valid_reg <= res_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                size_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        add_row_reg    <= add_row_next;
        add_col_reg    <= add_col_next;
        i_reg          <= i_next;
        j_reg          <= j_next;
        fetch_row_reg  <= fetch_row_next;
        tag_is_row_reg <= tag_is_row_next;
        tag_i_reg      <= tag_i_next;
        tag_j_reg      <= tag_j_next;
        ri_reg         <= ri_next;
        flags_reg      <= flags_next;
        res_reg        <= res_next;
    end

    // row memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            row_mem[add_row_reg] <= mem_wdata;
        end
        rd_data_reg  <= row_mem[rd_addr];
        rd_valid_reg <= row_valid_reg[rd_addr];
    end

`ifndef SYNTH
    a_tag_in_eval: assert property (@(posedge clk) disable iff (!rst_n)
        tag_valid_reg |-> (state_reg == S_EVAL || state_reg == S_DRAIN))
        else $error("compare stage active outside evaluation");

    a_add_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADD_WR) |=> (state_reg == S_IDLE))
        else $error("add write did not return to idle");

    a_res_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> (state_reg == S_IDLE && res_valid_reg))
        else $error("free output register not loaded");
`endif

endmodule

@@ tb/tb_relation_property_checker.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for relation_property_checker with a scoreboard that tracks the matrix.
module tb_relation_property_checker;
    import rpc_pkg::*;

    class relation_tracker;
        row_t              rows [MAX_ELEMENTS];
        logic [SIZE_W-1:0] size_reg;
        res_t              flags_due [$];
        int                mismatches;
        int                flags_checked;

        function new();
            foreach (rows[i]) rows[i] = '0;
            size_reg      = SIZE_RESET;
            mismatches    = 0;
            flags_checked = 0;
        endfunction

        function int active_n();
            return (size_reg > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(size_reg);
        endfunction

        function res_t properties();
            res_t f;
            int   n;
            row_t m;
            row_t ri;
            row_t rj;
            n = active_n();
            m = row_t'((32'd1 << n) - 1);
            f = '1;
            for (int i = 0; i < n; i++)
            begin
                ri = rows[i] & m;
                if (!ri[i])
                    f.is_reflexive = 1'b0;
                for (int j = 0; j < n; j++)
                begin
                    rj = rows[j] & m;
                    if (ri[j] != rj[i])
                        f.is_symmetric = 1'b0;
                    if (i != j && ri[j] && rj[i])
                        f.is_antisymmetric = 1'b0;
                    // i->j means everything reachable from j must be reachable from i
                    if (ri[j] && (rj & ~ri) != '0)
                        f.is_transitive = 1'b0;
                end
            end
            return f;
        endfunction

        function void take_cmd(cmd_t c);
            int n;
            n = active_n();
            case (c.op)
                OP_CLEAR: foreach (rows[i]) rows[i] = '0;
                OP_ADD:
                    if (c.row_index < n && c.col_index < n)
                        rows[c.row_index][c.col_index] = 1'b1;
                OP_EVAL:  flags_due.push_back(properties());
                default:  ;
            endcase
        endfunction

        function void check_bit(string field, logic want, logic got);
            if (got !== want)
            begin
                $error("%s: expected %0b, actual %0b", field, want, got);
                mismatches++;
            end
        endfunction

        function void check_flags(res_t got);
            res_t want;
            if (flags_due.size() == 0)
            begin
                $error("result word with no evaluate pending: %b", got);
                mismatches++;
                return;
            end
            want = flags_due.pop_front();
            flags_checked++;
            check_bit("is_reflexive", want.is_reflexive, got.is_reflexive);
            check_bit("is_symmetric", want.is_symmetric, got.is_symmetric);
            check_bit("is_antisymmetric", want.is_antisymmetric, got.is_antisymmetric);
            check_bit("is_transitive", want.is_transitive, got.is_transitive);
        endfunction
    endclass

    localparam logic [1:0] OP_UNUSED    = 2'd3;
    localparam int         RANDOM_ITEMS = 700;
    localparam int         PHASE_ITEMS  = 70;
    localparam int         QUIET_CYCLES = 8;
    localparam int         CYCLE_LIMIT  = 1500000;
    localparam int         IDLE_PCT     = 36;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cmd_valid = 1'b0;
    logic              cmd_stall;
    cmd_t              cmd       = '0;
    logic              res_valid;
    logic              res_stall = 1'b0;
    res_t              res;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SIZE_W-1:0] cfg_data  = '0;

    relation_tracker rel_model;
    logic            no_gaps       = 1'b0;
    int              items_sent    = 0;
    int              sizes_written = 0;
    int              cycles        = 0;

    relation_property_checker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(negedge clk)
        res_stall <= !no_gaps && ($urandom_range(0, 99) < IDLE_PCT);

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
                rel_model.take_cmd(cmd);
            if (res_valid && !res_stall)
                rel_model.check_flags(res);
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_relation_property_checker failed");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_cmd(logic [1:0] op, int r, int c);
        while (!no_gaps && $urandom_range(0, 99) < IDLE_PCT)
        begin
            cmd_valid = 1'b0;
            @(negedge clk);
        end
        cmd.op        = op;
        cmd.row_index = r[IDX_W-1:0];
        cmd.col_index = c[IDX_W-1:0];
        cmd_valid     = 1'b1;
        do @(posedge clk); while (cmd_stall);
        @(negedge clk);
        cmd_valid = 1'b0;
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    task automatic write_size(logic [SIZE_W-1:0] v);
        cfg_valid = 1'b1;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        rel_model.size_reg = v;
        sizes_written++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Adds may still be in flight after the last result, hence the extra cycles.
    task automatic wait_quiet();
        cmd_valid = 1'b0;
        while (rel_model.flags_due.size() != 0)
            @(negedge clk);
        repeat (QUIET_CYCLES) @(negedge clk);
    endtask

    // Mostly in range, sometimes anywhere in the 4-bit field.
    function automatic int pick_index(int n);
        if (n == 0 || $urandom_range(0, 4) == 0)
            return $urandom_range(0, 15);
        return $urandom_range(0, n - 1);
    endfunction

    // One relation build: optional clear, shaped adds, evaluate, maybe more adds and evaluate.
    task automatic run_group();
        int n;
        int shape;
        int nb;
        int i;
        int j;
        int blk [MAX_ELEMENTS];
        n = rel_model.active_n();
        if ($urandom_range(0, 3) != 0)
            send_cmd(OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15));
        shape = $urandom_range(0, 4);
        if (n > 8 && (shape == 1 || shape == 2) && $urandom_range(0, 3) != 0)
            shape = 0;
        nb = $urandom_range(1, 3);
        foreach (blk[k]) blk[k] = $urandom_range(0, nb - 1);
        case (shape)
            1:  // equivalence classes, occasionally missing a pair
                for (i = 0; i < n; i++)
                    for (j = 0; j < n; j++)
                        if (blk[i] == blk[j] && $urandom_range(0, 29) != 0)
                            send_cmd(OP_ADD, i, j);
            2:  // total order, occasionally missing a pair
                for (i = 0; i < n; i++)
                    for (j = i; j < n; j++)
                        if ($urandom_range(0, 29) != 0)
                            send_cmd(OP_ADD, i, j);
            3:
                repeat ($urandom_range(1, n + 2))
                begin
                    i = pick_index(n);
                    j = pick_index(n);
                    send_cmd(OP_ADD, i, j);
                    send_cmd(OP_ADD, j, i);
                end
            4:
            begin
                for (i = 0; i < n; i++)
                    if ($urandom_range(0, 9) != 0)
                        send_cmd(OP_ADD, i, i);
                repeat ($urandom_range(0, n))
                    send_cmd(OP_ADD, pick_index(n), pick_index(n));
            end
            default:
                repeat ($urandom_range(0, 2 * n + 2))
                    send_cmd(OP_ADD, pick_index(n), pick_index(n));
        endcase
        if ($urandom_range(0, 7) == 0)
            send_cmd(OP_UNUSED, $urandom_range(0, 15), $urandom_range(0, 15));
        send_cmd(OP_EVAL, $urandom_range(0, 15), $urandom_range(0, 15));
        if ($urandom_range(0, 2) == 0)
        begin
            repeat ($urandom_range(1, 2))
                send_cmd(OP_ADD, pick_index(n), pick_index(n));
            send_cmd(OP_EVAL, $urandom_range(0, 15), $urandom_range(0, 15));
        end
    endtask

    initial
    begin
        logic [SIZE_W-1:0] size_plan [10];
        int                phase;
        int                random_end;
        int                phase_end;
        size_plan = '{5'd2, 5'd3, 5'd16, 5'd4, 5'd1, 5'd0, 5'd5, 5'd17, 5'd8, 5'd31};
        rel_model = new();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty 16x16 relation: only reflexivity fails
        send_cmd(OP_EVAL, 0, 0);
        send_cmd(OP_ADD, 15, 15);
        send_cmd(OP_ADD, 0, 15);
        send_cmd(OP_EVAL, 15, 15);
        // both directions between 0 and 15: antisymmetry and transitivity break
        send_cmd(OP_ADD, 15, 0);
        send_cmd(OP_EVAL, 0, 0);
        send_cmd(OP_UNUSED, 15, 15);
        send_cmd(OP_EVAL, 0, 0);
        send_cmd(OP_CLEAR, 15, 15);
        send_cmd(OP_ADD, 0, 1);
        send_cmd(OP_ADD, 1, 2);
        send_cmd(OP_ADD, 5, 5);
        send_cmd(OP_EVAL, 0, 0);
        // zero size: everything holds vacuously, adds are dropped
        wait_quiet();
        write_size(5'd0);
        send_cmd(OP_ADD, 0, 0);
        send_cmd(OP_EVAL, 0, 0);
        // above the maximum: saturates to 16
        wait_quiet();
        write_size(5'd31);
        send_cmd(OP_ADD, 15, 14);
        send_cmd(OP_EVAL, 0, 0);
        // single element, with a pair just out of range; bits beyond n stay hidden
        wait_quiet();
        write_size(5'd1);
        send_cmd(OP_ADD, 0, 0);
        send_cmd(OP_ADD, 1, 1);
        send_cmd(OP_EVAL, 0, 0);
        // grow back: stored bits reappear
        wait_quiet();
        write_size(5'd16);
        send_cmd(OP_EVAL, 0, 0);

        random_end = items_sent + RANDOM_ITEMS;
        phase      = 0;
        while (items_sent < random_end)
        begin
            wait_quiet();
            no_gaps = 1'b0;
            write_size(phase < 10 ? size_plan[phase] : SIZE_W'($urandom_range(0, 31)));
            no_gaps   = (phase == 2);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end && items_sent < random_end)
                run_group();
            phase++;
        end
        no_gaps = 1'b0;
        wait_quiet();

        $display("%0d commands driven, %0d property words checked", items_sent,
                 rel_model.flags_checked);
        $display("%0d set-size writes, including empty, single and saturating sizes",
                 sizes_written);
        if (rel_model.mismatches == 0 && rel_model.flags_due.size() == 0)
            $display("tb_relation_property_checker passed");
        else
            $display("tb_relation_property_checker failed");
        $finish;
    end

endmodule
